[rtl/bee_pkg.sv]
package bee_pkg;

   // character codes used by the encoder
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_UP_A   = 8'h41;

   localparam logic [7:0] UTF_MASK2 = 8'hE0;
   localparam logic [7:0] UTF_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF_MASK3 = 8'hF0;
   localparam logic [7:0] UTF_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF_MASKC = 8'hC0;
   localparam logic [7:0] UTF_CONT  = 8'h80;

   // what the byte at the current position turns into
   typedef enum logic [2:0] {
      TK_NONE,    // nothing left, or waiting for more lookahead
      TK_PASS1,   // byte passes raw
      TK_UTF2,    // two-byte sequence passes raw
      TK_UTF3,    // three-byte sequence passes raw
      TK_ESC2,    // backslash + letter
      TK_HEX      // backslash x H H
   } tok_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;     // take the input item into the buffer
      logic emit;     // load next character into the output register
      logic commit;   // compact leftover bytes into the lookahead
   } cmd_type;

   typedef struct packed {
      logic cur_none;   // current token emits nothing
      logic tok_last;   // character index is the token's last
      logic next_none;  // token after the current one emits nothing
      logic slot_free;  // output register can take a character
   } stat_type;

   function automatic logic is_cont(logic [7:0] b);
      return (b & UTF_MASKC) == UTF_CONT;
   endfunction

   // second character of a short escape, zero when there is none
   function automatic logic [7:0] esc_letter(logic [7:0] c);
      logic [7:0] r;
      case (c)
         CH_BSLASH: r = CH_BSLASH;
         CH_LF:     r = CH_LOW_N;
         CH_CR:     r = CH_LOW_R;
         CH_BS:     r = CH_LOW_B;
         CH_TAB:    r = CH_LOW_T;
         CH_NUL:    r = CH_AT;
         default:   r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CH_ZERO + {4'h0, d};
      end else begin
         r = CH_UP_A + {4'h0, d} - 8'd10;
      end
      return r;
   endfunction

   function automatic tok_type decide(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                      logic [1:0] rem, logic fin, logic mode);
      tok_type t;
      tok_type esc;
      logic    last;
      esc  = (esc_letter(c0) != 8'h00) ? TK_ESC2 : TK_HEX;
      last = fin && (rem == 2'd1);
      if (rem == 2'd0) begin
         t = TK_NONE;
      end else if ((c0 >= CH_SPACE && c0 < CH_DEL && c0 != CH_BSLASH) ||
                   ((c0 == CH_LF || c0 == CH_TAB) && !mode) ||
                   (c0 == CH_NUL && last)) begin
         t = TK_PASS1;
      end else if ((c0 & UTF_MASK2) == UTF_LEAD2) begin
         if (rem < 2'd2) begin
            t = fin ? esc : TK_NONE;
         end else if (is_cont(c1)) begin
            t = TK_UTF2;
         end else begin
            t = esc;
         end
      end else if ((c0 & UTF_MASK3) == UTF_LEAD3) begin
         if (rem < 2'd2) begin
            t = fin ? esc : TK_NONE;
         end else if (!is_cont(c1)) begin
            t = esc;
         end else if (rem < 2'd3) begin
            t = fin ? esc : TK_NONE;
         end else if (is_cont(c2)) begin
            t = TK_UTF3;
         end else begin
            t = esc;
         end
      end else begin
         t = esc;
      end
      return t;
   endfunction

   function automatic logic [1:0] tok_last_idx(tok_type t);
      logic [1:0] r;
      case (t)
         TK_UTF2: r = 2'd1;
         TK_UTF3: r = 2'd2;
         TK_ESC2: r = 2'd1;
         TK_HEX:  r = 2'd3;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] tok_consume(tok_type t);
      logic [1:0] r;
      case (t)
         TK_NONE: r = 2'd0;
         TK_UTF2: r = 2'd2;
         TK_UTF3: r = 2'd3;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] char_at(tok_type t, logic [1:0] k,
                                          logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
      logic [7:0] r;
      case (t)
         TK_UTF2: r = (k == 2'd0) ? c0 : c1;
         TK_UTF3: r = (k == 2'd0) ? c0 : ((k == 2'd1) ? c1 : c2);
         TK_ESC2: r = (k == 2'd0) ? CH_BSLASH : esc_letter(c0);
         TK_HEX: begin
            case (k)
               2'd0:    r = CH_BSLASH;
               2'd1:    r = CH_LOW_X;
               2'd2:    r = hex_char(c0[7:4]);
               default: r = hex_char(c0[3:0]);
            endcase
         end
         default: r = c0;
      endcase
      return r;
   endfunction

endpackage

[rtl/bee_ctrl.sv]
module bee_ctrl
   import bee_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.cur_none) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else if (stat.slot_free) begin
               cmd.emit = 1'b1;
               // last character of the step: fold the commit in
               if (stat.tok_last && stat.next_none) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_emit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (stat.slot_free && !stat.cur_none))
      else $error("emit without free slot or token");

   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE))
      else $error("commit did not end the step");

endmodule

[rtl/bee_datapath.sv]
module bee_datapath
   import bee_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser,
   input  logic       csr_valid,
   input  logic       csr_data
);

   logic [7:0] buf_ff [3];
   logic [7:0] buf_in [3];
   logic [1:0] cnt_ff, cnt_in;     // lookahead count when idle, byte count when running
   logic [1:0] pos_ff, pos_in;
   logic [1:0] k_ff, k_in;         // character index within the token
   logic       fin_ff, fin_in;
   logic       mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_user_ff, rsp_user_in;

   logic [7:0] c0, c1, c2, n0, n1, n2;
   logic [1:0] rem, nrem, npos, base;
   tok_type    cur_tok, next_tok;
   logic       end_of_step;

   function automatic logic [7:0] byte_at(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                          logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = b0;
         3'd1:    r = b1;
         3'd2:    r = b2;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   always_comb begin
      c0      = byte_at(buf_ff[0], buf_ff[1], buf_ff[2], {1'b0, pos_ff});
      c1      = byte_at(buf_ff[0], buf_ff[1], buf_ff[2], {1'b0, pos_ff} + 3'd1);
      c2      = byte_at(buf_ff[0], buf_ff[1], buf_ff[2], {1'b0, pos_ff} + 3'd2);
      rem     = cnt_ff - pos_ff;
      cur_tok = decide(c0, c1, c2, rem, fin_ff, mode_ff);

      npos     = pos_ff + tok_consume(cur_tok);
      n0       = byte_at(buf_ff[0], buf_ff[1], buf_ff[2], {1'b0, npos});
      n1       = byte_at(buf_ff[0], buf_ff[1], buf_ff[2], {1'b0, npos} + 3'd1);
      n2       = byte_at(buf_ff[0], buf_ff[1], buf_ff[2], {1'b0, npos} + 3'd2);
      nrem     = cnt_ff - npos;
      next_tok = decide(n0, n1, n2, nrem, fin_ff, mode_ff);

      stat.cur_none  = (cur_tok == TK_NONE);
      stat.tok_last  = (k_ff == tok_last_idx(cur_tok));
      stat.next_none = (next_tok == TK_NONE);
      stat.slot_free = !rsp_valid_ff || rsp_tready;

      end_of_step = stat.tok_last && stat.next_none;
      base        = cmd.emit ? npos : pos_ff;
   end

   always_comb begin
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      fin_in       = fin_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;

      if (cmd.load) begin
         case (cnt_ff)
            2'd0:    buf_in[0] = req_tdata;
            2'd1:    buf_in[1] = req_tdata;
            default: buf_in[2] = req_tdata;
         endcase
         cnt_in = cnt_ff + 2'd1;
         pos_in = 2'd0;
         k_in   = 2'd0;
         fin_in = req_tlast;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = char_at(cur_tok, k_ff, c0, c1, c2);
         rsp_last_in  = end_of_step;
         rsp_user_in  = end_of_step && fin_ff;
         if (stat.tok_last) begin
            k_in   = 2'd0;
            pos_in = npos;
         end else begin
            k_in = k_ff + 2'd1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.commit) begin
         buf_in[0] = byte_at(buf_ff[0], buf_ff[1], buf_ff[2], {1'b0, base});
         buf_in[1] = byte_at(buf_ff[0], buf_ff[1], buf_ff[2], {1'b0, base} + 3'd1);
         cnt_in    = cnt_ff - base;
         pos_in    = 2'd0;
         k_in      = 2'd0;
      end

      if (csr_valid) begin
         mode_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 2'd0;
         pos_ff       <= 2'd0;
         k_ff         <= 2'd0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_lookahead_max: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (cnt_ff != 2'd3))
      else $error("lookahead holds more than two bytes");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> rsp_last_ff)
      else $error("string end flagged off a run end");

endmodule

[rtl/byte_escape_encoder.sv]
// Byte escape encoder: turns raw string bytes on req_* into printable escaped text on
// rsp_*, one character per item. Printable ASCII passes raw; backslash, CR and BS
// become two-character escapes, as do LF and TAB in single-line mode and NUL unless
// it is the last byte of a string (otherwise these pass raw). Other bytes become
// \xHH, and well-formed 2- and 3-byte UTF-8 passes raw. A UTF-8 lead byte is held
// (up to two bytes of lookahead) until its continuation bytes arrive; such a byte
// yields no characters yet. req_tlast marks the last byte of a string and flushes
// the lookahead. A byte yields up to 12 output characters. The controller handles one
// input byte at a time, so the rate is set by the single output character register.
// single_line_mode (csr_data) is written only while the block is idle.
module byte_escape_encoder
   import bee_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // is_final
   // output characters
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // run_end: last character of this input byte
   output logic       rsp_tuser,   // [0] string_done
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // single_line_mode
);

   cmd_type  cmd;
   stat_type stat;

   // mode write taken only between input items, never mid-step
   assign csr_ready = req_tready;

   bee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bee_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data)
   );

endmodule

[dv/byte_escape_encoder_chk.sv]
`timescale 1ns / 100ps

// Watches all three channels, predicts the escaped text for every accepted
// input item and compares each accepted output character in order.
module byte_escape_encoder_chk
   import bee_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   input  logic       rsp_tuser,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_data,
   output int         fail_count,
   output int         outstanding
);

   typedef struct packed {
      logic [7:0] ch;
      logic       run_end;
      logic       string_done;
   } text_char_type;

   text_char_type expected_text [$];

   // predictor state
   logic       single_line;
   logic [7:0] lookahead [0:1];
   int         lookahead_n;

   // characters produced by the item being predicted
   logic [7:0] staged [0:11];
   int         staged_n;

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic stage_char(input logic [7:0] c);
      if (staged_n < 12) begin
         staged[staged_n] = c;
         staged_n++;
      end
   endtask

   function automatic logic is_continuation(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] d);
      return (d < 4'd10) ? (8'h30 + 8'(d)) : (8'h41 + 8'(d) - 8'd10);
   endfunction

   task automatic stage_escape(input logic [7:0] c);
      logic [7:0] letter;
      case (c)
         CH_BSLASH: letter = CH_BSLASH;
         CH_LF:     letter = CH_LOW_N;
         CH_CR:     letter = CH_LOW_R;
         CH_BS:     letter = CH_LOW_B;
         CH_TAB:    letter = CH_LOW_T;
         CH_NUL:    letter = CH_AT;
         default:   letter = 8'h00;
      endcase
      stage_char(CH_BSLASH);
      if (letter != 8'h00) begin
         stage_char(letter);
      end else begin
         stage_char(CH_LOW_X);
         stage_char(hex_digit(c[7:4]));
         stage_char(hex_digit(c[3:0]));
      end
   endtask

   task automatic encode_byte(input logic [7:0] in_byte, input logic fin);
      logic [7:0]    seq [0:2];
      logic [7:0]    c;
      logic          waiting;
      logic          last;
      int            len;
      int            pos;
      int            rem;
      int            span;
      text_char_type t;
      len      = 0;
      pos      = 0;
      waiting  = 1'b0;
      staged_n = 0;
      for (int i = 0; i < lookahead_n; i++) begin
         seq[len] = lookahead[i];
         len++;
      end
      seq[len] = in_byte;
      len++;

      while (pos < len && !waiting) begin
         c    = seq[pos];
         rem  = len - pos;
         last = fin && rem == 1;
         if ((c >= CH_SPACE && c < CH_DEL && c != CH_BSLASH) ||
             ((c == CH_LF || c == CH_TAB) && !single_line) ||
             (c == CH_NUL && last)) begin
            stage_char(c);
            pos++;
         end else begin
            span = 0;
            if (c[7:5] == 3'b110) begin
               if (rem < 2) begin
                  waiting = !fin;
               end else if (is_continuation(seq[pos + 1])) begin
                  span = 2;
               end
            end else if (c[7:4] == 4'b1110) begin
               if (rem < 2) begin
                  waiting = !fin;
               end else if (is_continuation(seq[pos + 1])) begin
                  if (rem < 3) begin
                     waiting = !fin;
                  end else if (is_continuation(seq[pos + 2])) begin
                     span = 3;
                  end
               end
            end
            if (!waiting) begin
               if (span == 0) begin
                  stage_escape(c);
                  pos++;
               end else begin
                  for (int k = 0; k < span; k++) stage_char(seq[pos + k]);
                  pos += span;
               end
            end
         end
      end

      lookahead_n = 0;
      for (int i = pos; i < len && lookahead_n < 2; i++) begin
         lookahead[lookahead_n] = seq[i];
         lookahead_n++;
      end

      for (int i = 0; i < staged_n; i++) begin
         t.ch          = staged[i];
         t.run_end     = (i == staged_n - 1);
         t.string_done = (i == staged_n - 1) && fin;
         expected_text.push_back(t);
      end
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         single_line = 1'b0;
         lookahead_n = 0;
         expected_text.delete();
      end else begin
         if (csr_valid && csr_ready) single_line = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected char %02h", rsp_tdata));
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.ch || rsp_tlast !== want.run_end ||
                   rsp_tuser !== want.string_done) begin
                  report_mismatch($sformatf(
                     "char got %02h last %b done %b, want %02h last %b done %b",
                     rsp_tdata, rsp_tlast, rsp_tuser,
                     want.ch, want.run_end, want.string_done));
               end
            end
         end
         if (req_tvalid && req_tready) encode_byte(req_tdata, req_tlast);
      end
      outstanding = expected_text.size();
   end

endmodule

[dv/byte_escape_encoder_tb.sv]
`timescale 1ns / 100ps

// Top of the encoder bench: clock, reset, byte and mode stimulus, output
// back-pressure and the verdict. All checking lives in the checker.
module byte_escape_encoder_tb
   import bee_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   // quiet cycles so a held byte with no characters is fully absorbed
   localparam int SETTLE      = 8;
   localparam int PHASE_ITEMS = 32;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tlast  = 1'b0;    // is_final
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_char
   logic       rsp_tlast;            // run_end
   logic       rsp_tuser;            // [0] string_done
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic       csr_data   = 1'b0;    // single_line_mode

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   int items_sent  = 0;
   int stall_left  = 0;
   bit calm        = 1'b0;           // no idling on either side when set

   logic [7:0] text_bytes [$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   byte_escape_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   byte_escape_encoder_chk checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("byte_escape_encoder_tb: errors");
         $finish;
      end
   end

   // output back-pressure: random stall bursts, none once calm
   always @(negedge clock) begin
      if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 14);
      end
      rsp_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
   end

   // one byte on the request channel; valid stays high into the next item
   // unless a gap is taken first
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // drop valid, wait for every predicted char, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_special();
      case ($urandom_range(0, 6))
         0:       return CH_BSLASH;
         1:       return CH_LF;
         2:       return CH_TAB;
         3:       return CH_CR;
         4:       return CH_BS;
         5:       return CH_NUL;
         default: return CH_DEL;
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // any byte that is not a UTF-8 continuation
   function automatic logic [7:0] non_cont_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b = b ^ 8'h40;
      return b;
   endfunction

   // a string of mostly well-formed tokens, tlast on its last byte
   task automatic send_text();
      int target;
      target = $urandom_range(1, 10);
      text_bytes.delete();
      while (text_bytes.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            3:       text_bytes.push_back(pick_special());
            4:       text_bytes.push_back(8'($urandom_range(0, 255)));
            5: begin
               text_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
               text_bytes.push_back(cont_byte());
            end
            6: begin
               text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
               text_bytes.push_back(cont_byte());
               text_bytes.push_back(cont_byte());
            end
            7: begin
               // broken or cut-short sequence
               case ($urandom_range(0, 3))
                  0: begin
                     text_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                     text_bytes.push_back(non_cont_byte());
                  end
                  1: begin
                     text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                     text_bytes.push_back(cont_byte());
                     text_bytes.push_back(non_cont_byte());
                  end
                  2: text_bytes.push_back(8'($urandom_range(8'hC0, 8'hEF)));
                  default: begin
                     text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                     text_bytes.push_back(cont_byte());
                  end
               endcase
            end
            8:       text_bytes.push_back(cont_byte());
            default: text_bytes.push_back(CH_NUL);
         endcase
      end
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      // directed: printable edges and DEL
      send_byte(8'h41, 1'b0);
      send_byte(CH_SPACE, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(CH_DEL, 1'b0);
      // short escapes, LF/TAB raw in multi-line mode
      send_byte(CH_BSLASH, 1'b0);
      send_byte(CH_LF, 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(CH_BS, 1'b0);
      // NUL mid-string escapes, NUL as last byte passes raw
      send_byte(CH_NUL, 1'b0);
      send_byte(CH_NUL, 1'b1);
      send_byte(8'hFF, 1'b1);
      // good 2- and 3-byte sequences
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b1);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b1);
      // broken sequences: lead escaped, following bytes decided again
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h41, 1'b1);
      // string ends inside a sequence
      send_byte(8'hC3, 1'b1);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);

      // one-line mode escapes LF and TAB
      write_mode(1'b1);
      send_byte(CH_LF, 1'b0);
      send_byte(CH_TAB, 1'b1);
      // mode flips while a lead byte sits in the lookahead
      send_byte(8'hC3, 1'b0);
      write_mode(1'b0);
      send_byte(CH_LF, 1'b1);

      // random phases, each under its own mode setting
      for (int phase = 0; phase < 6; phase++) begin
         int phase_start;
         case (phase)
            0:       write_mode(1'b1);
            1:       write_mode(1'b0);
            5:       write_mode(1'b1);
            default: write_mode(1'($urandom_range(0, 1)));
         endcase
         calm = (phase == 5);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
               send_text();
            end else begin
               // noise: raw bytes, strings may run across phase boundaries
               repeat ($urandom_range(1, 6)) begin
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
               end
            end
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("byte_escape_encoder_tb: clean");
      end else begin
         $display("byte_escape_encoder_tb: errors");
      end
      $finish;
   end

endmodule
